>>> src/fscan_disk_request_scheduler_top_macros.svh
// assertion macros for the fscan disk request scheduler
// no dependencies; included by the modules that carry assertions
`ifndef FSCAN_DISK_REQUEST_SCHEDULER_TOP_MACROS_SVH
`define FSCAN_DISK_REQUEST_SCHEDULER_TOP_MACROS_SVH
`ifndef SYNTH
`define FSCAN_ASSERT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("fscan assertion failed");
`define FSCAN_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("fscan assertion failed");
`else
`define FSCAN_ASSERT(label, clk, rst_n, ante, cons)
`define FSCAN_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

>>> src/fscan_pkg.sv
// shared constants, entry type and controller/datapath command and status structs
// no dependencies
package fscan_pkg;

    localparam int QUEUE_DEPTH_DEF     = 16;
    localparam int BLOCKS_PER_CYLINDER = 24;

    // field widths
    localparam int TAG_W     = 8;
    localparam int UNIT_W    = 2;
    localparam int BLOCK_W   = 16;
    localparam int STATUS_W  = 3;
    localparam int CYL_W     = 12;
    localparam int SEC_W     = 6;
    localparam int BPD_W     = 16;
    localparam int DCNT_W    = 3;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DAT_W = 16;

    // register indexes and reset values
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCKS_PER_DISK = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_DISK_COUNT      = 1'b1;
    localparam logic [BPD_W-1:0]     BLOCKS_PER_DISK_RST = 16'd9792;
    localparam logic [DCNT_W-1:0]    DISK_COUNT_RST      = 3'd2;

    // function codes
    localparam logic FUNC_SUBMIT   = 1'b0;
    localparam logic FUNC_DISPATCH = 1'b1;

    // status codes
    localparam logic [STATUS_W-1:0] ST_QUEUED     = 3'd0;
    localparam logic [STATUS_W-1:0] ST_BAD_UNIT   = 3'd1;
    localparam logic [STATUS_W-1:0] ST_PAST_EOF   = 3'd2;
    localparam logic [STATUS_W-1:0] ST_PAST_ERR   = 3'd3;
    localparam logic [STATUS_W-1:0] ST_FULL       = 3'd4;
    localparam logic [STATUS_W-1:0] ST_DISPATCHED = 3'd5;
    localparam logic [STATUS_W-1:0] ST_NONE       = 3'd6;

    // block / 24 as multiply by rounded-up reciprocal and shift
    localparam int                 CYL_SHIFT = 20;
    localparam logic [BLOCK_W-1:0] CYL_RECIP =
        BLOCK_W'((1 << CYL_SHIFT) / BLOCKS_PER_CYLINDER + 1);

    // sector mapping
    localparam logic [SEC_W-1:0] SECTOR_WRAP = SEC_W'(BLOCKS_PER_CYLINDER);
    localparam logic [SEC_W-1:0] SECTOR_GAP  = SEC_W'(32 - 24);

    typedef struct packed {
        logic [TAG_W-1:0] tag;
        logic [CYL_W-1:0] cyl;
        logic [SEC_W-1:0] sec;
    } t_entry;

    typedef struct packed {
        logic load;       // latch the incoming transaction
        logic check;      // register sector, evaluate checks
        logic reject;     // stage reject result
        logic scan_init;  // start insertion scan at tail of next pass
        logic shift;      // move scanned entry one slot up
        logic insert;     // write new entry, stage queued result
        logic swap;       // next pass becomes current, flip direction
        logic pop_rd;     // read head of current pass
        logic pop;        // remove head, stage dispatched result
        logic none_rsp;   // stage nothing-pending result
        logic emit;       // move staged result to output register
    } t_cmd;

    typedef struct packed {
        logic in_func;
        logic reject;
        logic next_empty;
        logic cur_empty;
        logic stays;
        logic ptr_zero;
        logic out_free;
    } t_stat;

endpackage

>>> src/fscan_req_if.sv
// request channel: submit or dispatch transactions
// depends on fscan_pkg
interface fscan_req_if;
    logic                               valid;
    logic                               ready;
    logic                               func;
    logic [fscan_pkg::TAG_W-1:0]        request_tag;
    logic [fscan_pkg::UNIT_W-1:0]       disk_unit;
    logic [fscan_pkg::BLOCK_W-1:0]      block_number;
    logic                               raw_read;

    modport source (output valid, func, request_tag, disk_unit, block_number, raw_read,
                    input ready);
    modport sink (input valid, func, request_tag, disk_unit, block_number, raw_read,
                  output ready);
endinterface

>>> src/fscan_rsp_if.sv
// response channel: one result per request transaction
// depends on fscan_pkg
interface fscan_rsp_if;
    logic                               valid;
    logic                               ready;
    logic [fscan_pkg::STATUS_W-1:0]     status;
    logic [fscan_pkg::TAG_W-1:0]        out_tag;
    logic [fscan_pkg::CYL_W-1:0]        cylinder;
    logic [fscan_pkg::SEC_W-1:0]        sector;
    logic                               direction;

    modport source (output valid, status, out_tag, cylinder, sector, direction,
                    input ready);
    modport sink (input valid, status, out_tag, cylinder, sector, direction,
                  output ready);
endinterface

>>> src/fscan_cfg_if.sv
// configuration write channel
// depends on fscan_pkg
interface fscan_cfg_if;
    logic                               valid;
    logic                               ready;
    logic [fscan_pkg::CFG_IDX_W-1:0]    index;
    logic [fscan_pkg::CFG_DAT_W-1:0]    data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

>>> src/fscan_ctrl.sv
// controller state machine: sequences submit insertion and dispatch
// depends on fscan_pkg; drives fscan_dp through t_cmd, reads t_stat
module fscan_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_req_valid,
    output logic             o_req_ready,
    input  fscan_pkg::t_stat i_stat,
    output fscan_pkg::t_cmd  o_cmd
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CHECK = 3'd1;
    localparam logic [2:0] S_SCAN  = 3'd2;
    localparam logic [2:0] S_INS   = 3'd3;
    localparam logic [2:0] S_DISP  = 3'd4;
    localparam logic [2:0] S_DRD   = 3'd5;
    localparam logic [2:0] S_DWAIT = 3'd6;
    localparam logic [2:0] S_OUT   = 3'd7;

    logic [2:0] r_state;
    logic [2:0] n_state;

    assign o_req_ready = (r_state == S_IDLE);

    // next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_req_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = (i_stat.in_func == fscan_pkg::FUNC_DISPATCH) ? S_DISP
                                                                               : S_CHECK;
                end
            end
            S_CHECK: begin
                o_cmd.check = 1'b1;
                if (i_stat.reject) begin
                    o_cmd.reject = 1'b1;
                    n_state      = S_OUT;
                end else begin
                    o_cmd.scan_init = 1'b1;
                    n_state         = i_stat.next_empty ? S_INS : S_SCAN;
                end
            end
            S_SCAN: begin
                if (i_stat.stays) begin
                    n_state = S_INS;
                end else begin
                    o_cmd.shift = 1'b1;
                    if (i_stat.ptr_zero) begin
                        n_state = S_INS;
                    end
                end
            end
            S_INS: begin
                o_cmd.insert = 1'b1;
                n_state      = S_OUT;
            end
            S_DISP: begin
                if (!i_stat.cur_empty) begin
                    n_state = S_DRD;
                end else if (i_stat.next_empty) begin
                    o_cmd.none_rsp = 1'b1;
                    n_state        = S_OUT;
                end else begin
                    o_cmd.swap = 1'b1;
                    n_state    = S_DRD;
                end
            end
            S_DRD: begin
                o_cmd.pop_rd = 1'b1;
                n_state      = S_DWAIT;
            end
            S_DWAIT: begin
                o_cmd.pop = 1'b1;
                n_state   = S_OUT;
            end
            S_OUT: begin
                if (i_stat.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

>>> src/fscan_dp.sv
// datapath: config registers, cylinder/sector mapping, two-bank queue memory,
// counters, staged result and output register; depends on fscan_pkg and macros
`include "fscan_disk_request_scheduler_top_macros.svh"
module fscan_dp #(
    parameter int QUEUE_DEPTH = fscan_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  fscan_pkg::t_cmd                   i_cmd,
    output fscan_pkg::t_stat                  o_stat,
    input  logic                              i_func,
    input  logic [fscan_pkg::TAG_W-1:0]       i_request_tag,
    input  logic [fscan_pkg::UNIT_W-1:0]      i_disk_unit,
    input  logic [fscan_pkg::BLOCK_W-1:0]     i_block_number,
    input  logic                              i_raw_read,
    input  logic                              i_cfg_valid,
    input  logic [fscan_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [fscan_pkg::CFG_DAT_W-1:0]   i_cfg_data,
    input  logic                              i_rsp_ready,
    output logic                              o_rsp_valid,
    output logic [fscan_pkg::STATUS_W-1:0]    o_status,
    output logic [fscan_pkg::TAG_W-1:0]       o_out_tag,
    output logic [fscan_pkg::CYL_W-1:0]       o_cylinder,
    output logic [fscan_pkg::SEC_W-1:0]       o_sector,
    output logic                              o_direction
);

    localparam int IDX_W  = $clog2(QUEUE_DEPTH);
    localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
    localparam int ADDR_W = IDX_W + 1;
    localparam int MEM_D  = 2 ** ADDR_W;
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);

    // configuration
    logic [fscan_pkg::BPD_W-1:0]  r_bpd;
    logic [fscan_pkg::DCNT_W-1:0] r_dcnt;

    // latched request
    logic [fscan_pkg::TAG_W-1:0]   r_tag;
    logic [fscan_pkg::UNIT_W-1:0]  r_unit;
    logic [fscan_pkg::BLOCK_W-1:0] r_blk;
    logic                          r_raw;
    logic [fscan_pkg::CYL_W-1:0]   r_cyl;
    logic [fscan_pkg::SEC_W-1:0]   r_sec;

    // queue state; bank r_sel holds the next pass, the other bank the current pass
    logic              r_sel;
    logic              r_dir;
    logic [CNT_W-1:0]  r_next_cnt;
    logic [CNT_W-1:0]  r_cur_cnt;
    logic [IDX_W-1:0]  r_head;
    logic [IDX_W-1:0]  r_ptr;
    logic [IDX_W-1:0]  r_pos;

    fscan_pkg::t_entry r_mem [MEM_D];
    fscan_pkg::t_entry r_rd_data;

    // staged result and output register
    logic [fscan_pkg::STATUS_W-1:0] r_res_status;
    logic [fscan_pkg::TAG_W-1:0]    r_res_tag;
    logic [fscan_pkg::CYL_W-1:0]    r_res_cyl;
    logic [fscan_pkg::SEC_W-1:0]    r_res_sec;
    logic                           r_out_valid;
    logic [fscan_pkg::STATUS_W-1:0] r_out_status;
    logic [fscan_pkg::TAG_W-1:0]    r_out_tag;
    logic [fscan_pkg::CYL_W-1:0]    r_out_cyl;
    logic [fscan_pkg::SEC_W-1:0]    r_out_sec;
    logic                           r_out_dir;

    logic [2*fscan_pkg::BLOCK_W-1:0] w_prod;
    logic [fscan_pkg::BLOCK_W-1:0]   w_cyl24;
    logic [fscan_pkg::BLOCK_W-1:0]   w_rem;
    logic [fscan_pkg::SEC_W-1:0]     w_sec2;
    logic [fscan_pkg::SEC_W-1:0]     w_sec;
    logic                            w_rej;
    logic [fscan_pkg::STATUS_W-1:0]  w_rej_code;
    logic                            w_stays;
    logic [CNT_W-1:0]                w_cnt_m1;
    logic [ADDR_W-1:0]               w_rd_addr;
    logic [ADDR_W-1:0]               w_wr_addr;
    fscan_pkg::t_entry               w_wr_data;
    logic                            w_we;

    // cylinder by reciprocal multiply, sector from remainder
    assign w_prod  = i_block_number * fscan_pkg::CYL_RECIP;
    assign w_cyl24 = {r_cyl, 4'b0000} + {1'b0, r_cyl, 3'b000};
    assign w_rem   = r_blk - w_cyl24;
    assign w_sec2  = {w_rem[4:0], 1'b0};
    assign w_sec   = (w_sec2 >= fscan_pkg::SECTOR_WRAP) ? w_sec2 + fscan_pkg::SECTOR_GAP
                                                        : w_sec2;

    // unit, bound and full checks in priority order
    always_comb begin
        w_rej      = 1'b1;
        w_rej_code = fscan_pkg::ST_QUEUED;
        if ({1'b0, r_unit} >= r_dcnt) begin
            w_rej_code = fscan_pkg::ST_BAD_UNIT;
        end else if (r_blk >= r_bpd) begin
            w_rej_code = r_raw ? fscan_pkg::ST_PAST_EOF : fscan_pkg::ST_PAST_ERR;
        end else if (r_next_cnt == FULL_CNT) begin
            w_rej_code = fscan_pkg::ST_FULL;
        end else begin
            w_rej = 1'b0;
        end
    end

    // scanned entry stays ahead of the new one
    assign w_stays = r_dir ? (r_rd_data.cyl <= r_cyl) : (r_rd_data.cyl >= r_cyl);

    assign o_stat.in_func    = i_func;
    assign o_stat.reject     = w_rej;
    assign o_stat.next_empty = (r_next_cnt == '0);
    assign o_stat.cur_empty  = (r_cur_cnt == '0);
    assign o_stat.stays      = w_stays;
    assign o_stat.ptr_zero   = (r_ptr == '0);
    assign o_stat.out_free   = !r_out_valid || i_rsp_ready;

    // memory addressing
    assign w_cnt_m1 = r_next_cnt - CNT_W'(1);

    always_comb begin
        w_rd_addr = {r_sel, r_ptr - IDX_W'(1)};
        if (i_cmd.scan_init) begin
            w_rd_addr = {r_sel, w_cnt_m1[IDX_W-1:0]};
        end else if (i_cmd.pop_rd) begin
            w_rd_addr = {~r_sel, r_head};
        end
    end

    assign w_we      = i_cmd.shift || i_cmd.insert;
    assign w_wr_addr = {r_sel, r_pos};
    assign w_wr_data = i_cmd.shift ? r_rd_data
                                   : fscan_pkg::t_entry'{tag: r_tag, cyl: r_cyl, sec: r_sec};

    // queue memory, one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_wr_addr] <= w_wr_data;
        end
        r_rd_data <= r_mem[w_rd_addr];
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bpd       <= fscan_pkg::BLOCKS_PER_DISK_RST;
            r_dcnt      <= fscan_pkg::DISK_COUNT_RST;
            r_sel       <= 1'b0;
            r_dir       <= 1'b0;
            r_next_cnt  <= '0;
            r_cur_cnt   <= '0;
            r_head      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    fscan_pkg::CFG_BLOCKS_PER_DISK: r_bpd  <= i_cfg_data;
                    fscan_pkg::CFG_DISK_COUNT:      r_dcnt <= i_cfg_data[fscan_pkg::DCNT_W-1:0];
                    default: begin
                    end
                endcase
            end
            if (i_cmd.insert) begin
                r_next_cnt <= r_next_cnt + CNT_W'(1);
            end
            if (i_cmd.swap) begin
                r_sel      <= ~r_sel;
                r_dir      <= ~r_dir;
                r_cur_cnt  <= r_next_cnt;
                r_next_cnt <= '0;
                r_head     <= '0;
            end
            if (i_cmd.pop) begin
                r_head    <= r_head + IDX_W'(1);
                r_cur_cnt <= r_cur_cnt - CNT_W'(1);
            end
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_rsp_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_tag  <= i_request_tag;
            r_unit <= i_disk_unit;
            r_blk  <= i_block_number;
            r_raw  <= i_raw_read;
            r_cyl  <= w_prod[fscan_pkg::CYL_SHIFT +: fscan_pkg::CYL_W];
        end
        if (i_cmd.check) begin
            r_sec <= w_sec;
        end
        if (i_cmd.scan_init) begin
            r_ptr <= w_cnt_m1[IDX_W-1:0];
            r_pos <= r_next_cnt[IDX_W-1:0];
        end
        if (i_cmd.shift) begin
            r_ptr <= r_ptr - IDX_W'(1);
            r_pos <= r_ptr;
        end
        if (i_cmd.reject) begin
            r_res_status <= w_rej_code;
            r_res_tag    <= '0;
            r_res_cyl    <= '0;
            r_res_sec    <= '0;
        end
        if (i_cmd.insert) begin
            r_res_status <= fscan_pkg::ST_QUEUED;
            r_res_tag    <= '0;
            r_res_cyl    <= r_cyl;
            r_res_sec    <= r_sec;
        end
        if (i_cmd.none_rsp) begin
            r_res_status <= fscan_pkg::ST_NONE;
            r_res_tag    <= '0;
            r_res_cyl    <= '0;
            r_res_sec    <= '0;
        end
        if (i_cmd.pop) begin
            r_res_status <= fscan_pkg::ST_DISPATCHED;
            r_res_tag    <= r_rd_data.tag;
            r_res_cyl    <= r_rd_data.cyl;
            r_res_sec    <= r_rd_data.sec;
        end
        if (i_cmd.emit) begin
            r_out_status <= r_res_status;
            r_out_tag    <= r_res_tag;
            r_out_cyl    <= r_res_cyl;
            r_out_sec    <= r_res_sec;
            r_out_dir    <= r_dir;
        end
    end

    assign o_rsp_valid = r_out_valid;
    assign o_status    = r_out_status;
    assign o_out_tag   = r_out_tag;
    assign o_cylinder  = r_out_cyl;
    assign o_sector    = r_out_sec;
    assign o_direction = r_out_dir;

    // queue bookkeeping checks
    `FSCAN_ASSERT(a_swap_when_cur_empty, i_clk, i_rst_n, i_cmd.swap,
                  (r_cur_cnt == '0) && (r_next_cnt != '0))
    `FSCAN_ASSERT_NEXT(a_swap_flips_dir, i_clk, i_rst_n, i_cmd.swap, r_dir != $past(r_dir))
    `FSCAN_ASSERT(a_insert_not_full, i_clk, i_rst_n, i_cmd.insert, r_next_cnt < FULL_CNT)
    `FSCAN_ASSERT(a_pop_not_empty, i_clk, i_rst_n, i_cmd.pop, r_cur_cnt != '0)
    `FSCAN_ASSERT(a_cur_in_bank, i_clk, i_rst_n, 1'b1,
                  ((CNT_W+1)'(r_head) + (CNT_W+1)'(r_cur_cnt)) <= (CNT_W+1)'(QUEUE_DEPTH))

endmodule

>>> src/fscan_disk_request_scheduler_top.sv
// submit: a rejected request goes from the check state to the output state; an accepted one
// scans the next pass from its tail, moving each entry that sorts after it up one slot, then inserts
// dispatch: none when both passes are empty, else swap if current is empty, then pop its head
// throughput: one request in flight; the next is taken back in idle after the result is
// registered, later while the output register waits on the receiver
// reset: queues empty, direction descending, registers to defaults; no clearing pass
// top level of the fscan disk request scheduler; depends on fscan_pkg, the channel
// interfaces, fscan_ctrl and fscan_dp
module fscan_disk_request_scheduler_top #(
    parameter int QUEUE_DEPTH = fscan_pkg::QUEUE_DEPTH_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    fscan_req_if.sink    i_req,
    fscan_cfg_if.sink    i_cfg,
    fscan_rsp_if.source  o_rsp
);

    fscan_pkg::t_cmd  w_cmd;
    fscan_pkg::t_stat w_stat;
    logic             w_req_ready;

    // configuration writes are always taken
    assign i_cfg.ready = 1'b1;
    assign i_req.ready = w_req_ready;

    // sequencer
    fscan_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .o_req_ready (w_req_ready),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd)
    );

    // queues and arithmetic
    fscan_dp #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .o_stat         (w_stat),
        .i_func         (i_req.func),
        .i_request_tag  (i_req.request_tag),
        .i_disk_unit    (i_req.disk_unit),
        .i_block_number (i_req.block_number),
        .i_raw_read     (i_req.raw_read),
        .i_cfg_valid    (i_cfg.valid),
        .i_cfg_index    (i_cfg.index),
        .i_cfg_data     (i_cfg.data),
        .i_rsp_ready    (o_rsp.ready),
        .o_rsp_valid    (o_rsp.valid),
        .o_status       (o_rsp.status),
        .o_out_tag      (o_rsp.out_tag),
        .o_cylinder     (o_rsp.cylinder),
        .o_sector       (o_rsp.sector),
        .o_direction    (o_rsp.direction)
    );

endmodule

>>> sim/fscan_disk_request_scheduler_top_tb.sv
// self-checking testbench for the fscan disk request scheduler: directed, back-pressure
// and random traffic against an in-bench scheduling model, one result per transaction
// depends on fscan_pkg, the channel interfaces and fscan_disk_request_scheduler_top
module fscan_disk_request_scheduler_top_tb;

    localparam int QDEPTH           = fscan_pkg::QUEUE_DEPTH_DEF;
    localparam int HALF_SLOTS       = 48;       // two sectors per block, 48 per track
    localparam int SECTOR_SPLIT     = 24;
    localparam int SECTOR_SKIP      = 32 - 24;
    localparam int CYCLE_LIMIT      = 200000;
    localparam int DRAIN_CYCLES     = 40;
    localparam int LONG_HOLD_CYCLES = 300;
    localparam int RANDOM_PHASES    = 8;
    localparam int ITEMS_PER_PHASE  = 42;

    typedef struct {
        logic                          func;
        logic [fscan_pkg::TAG_W-1:0]   tag;
        logic [fscan_pkg::UNIT_W-1:0]  unit;
        logic [fscan_pkg::BLOCK_W-1:0] block;
        logic                          raw;
    } t_disk_request;

    typedef struct {
        logic [fscan_pkg::STATUS_W-1:0] status;
        logic [fscan_pkg::TAG_W-1:0]    tag;
        logic [fscan_pkg::CYL_W-1:0]    cyl;
        logic [fscan_pkg::SEC_W-1:0]    sec;
        logic                           dir;
    } t_disk_result;

    typedef enum int {RSP_ALWAYS, RSP_RANDOM, RSP_SPARSE, RSP_PERIODIC} t_rsp_mode;

    logic i_clk;
    logic i_rst_n;

    fscan_req_if req_if();
    fscan_cfg_if cfg_if();
    fscan_rsp_if rsp_if();

    fscan_disk_request_scheduler_top #(
        .QUEUE_DEPTH(QDEPTH)
    ) i_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (req_if),
        .i_cfg  (cfg_if),
        .o_rsp  (rsp_if)
    );

    // scheduler state mirrored in the bench
    logic [fscan_pkg::BPD_W-1:0]  blocks_per_disk_q = fscan_pkg::BLOCKS_PER_DISK_RST;
    logic [fscan_pkg::DCNT_W-1:0] disk_count_q      = fscan_pkg::DISK_COUNT_RST;
    fscan_pkg::t_entry            next_sweep[$];
    fscan_pkg::t_entry            current_sweep[$];
    logic                         sweep_dir = 1'b0;
    t_disk_result                 pending_results[$];

    int        error_count       = 0;
    int        cycle_count       = 0;
    int        burst_left        = 0;
    bit        long_hold_request = 1'b0;
    t_rsp_mode stall_mode        = RSP_ALWAYS;
    int        mode_left         = 0;
    int        pattern_count     = 0;
    int        hold_count;

    // clock
    initial i_clk = 1'b0;
    always #1 i_clk = ~i_clk;

    // run limit
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // scheduling of one transaction: result and state update
    function automatic t_disk_result schedule_item(input t_disk_request r);
        t_disk_result      res;
        fscan_pkg::t_entry e;
        int                pos;
        int                sec;
        res = '{default: '0};
        if (r.func == fscan_pkg::FUNC_SUBMIT) begin
            if (r.unit >= disk_count_q) begin
                res.status = fscan_pkg::ST_BAD_UNIT;
            end else if (r.block >= blocks_per_disk_q) begin
                res.status = r.raw ? fscan_pkg::ST_PAST_EOF : fscan_pkg::ST_PAST_ERR;
            end else if (next_sweep.size() >= QDEPTH) begin
                res.status = fscan_pkg::ST_FULL;
            end else begin
                sec = (int'(r.block) * 2) % HALF_SLOTS;
                if (sec >= SECTOR_SPLIT) sec += SECTOR_SKIP;
                e.tag = r.tag;
                e.cyl = fscan_pkg::CYL_W'(int'(r.block) / fscan_pkg::BLOCKS_PER_CYLINDER);
                e.sec = fscan_pkg::SEC_W'(sec);
                // sorted insert, after any equal cylinders
                pos = 0;
                while (pos < next_sweep.size() &&
                       (sweep_dir ? (next_sweep[pos].cyl <= e.cyl)
                                  : (next_sweep[pos].cyl >= e.cyl)))
                    pos++;
                next_sweep.insert(pos, e);
                res.status = fscan_pkg::ST_QUEUED;
                res.cyl    = e.cyl;
                res.sec    = e.sec;
            end
        end else if (current_sweep.size() == 0 && next_sweep.size() == 0) begin
            res.status = fscan_pkg::ST_NONE;
        end else begin
            // current pass exhausted: swap passes and reverse the sweep
            if (current_sweep.size() == 0) begin
                current_sweep = next_sweep;
                next_sweep.delete();
                sweep_dir = ~sweep_dir;
            end
            e = current_sweep.pop_front();
            res.status = fscan_pkg::ST_DISPATCHED;
            res.tag    = e.tag;
            res.cyl    = e.cyl;
            res.sec    = e.sec;
        end
        res.dir = sweep_dir;
        return res;
    endfunction

    // request sender: bursts of random length with random gaps
    task automatic send_request(input t_disk_request r);
        int gap;
        @(negedge i_clk);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            gap = $urandom_range(0, 6);
            if (gap > 0) begin
                req_if.valid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
        end
        burst_left--;
        req_if.valid        <= 1'b1;
        req_if.func         <= r.func;
        req_if.request_tag  <= r.tag;
        req_if.disk_unit    <= r.unit;
        req_if.block_number <= r.block;
        req_if.raw_read     <= r.raw;
        do @(posedge i_clk); while (!req_if.ready);
        pending_results.push_back(schedule_item(r));
    endtask

    task automatic send_fields(input logic func, input int tag, input int unit,
                               input int block, input logic raw);
        t_disk_request r;
        r.func  = func;
        r.tag   = fscan_pkg::TAG_W'(tag);
        r.unit  = fscan_pkg::UNIT_W'(unit);
        r.block = fscan_pkg::BLOCK_W'(block);
        r.raw   = raw;
        send_request(r);
    endtask

    // stop offering and wait until every result is back
    task automatic wait_for_idle();
        @(negedge i_clk);
        req_if.valid <= 1'b0;
        burst_left = 0;
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    // register write, only while the scheduler is idle
    task automatic write_register(input logic [fscan_pkg::CFG_IDX_W-1:0] idx,
                                  input logic [fscan_pkg::CFG_DAT_W-1:0] data);
        @(negedge i_clk);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= data;
        do @(posedge i_clk); while (!cfg_if.ready);
        if (idx == fscan_pkg::CFG_BLOCKS_PER_DISK)
            blocks_per_disk_q = data[fscan_pkg::BPD_W-1:0];
        else
            disk_count_q = data[fscan_pkg::DCNT_W-1:0];
        @(negedge i_clk);
        cfg_if.valid <= 1'b0;
    endtask

    // random submits and dispatches; submits mostly well-formed, with some bad units and past-end blocks
    function automatic t_disk_request random_request(input int submit_pct);
        t_disk_request r;
        int units;
        int bpd;
        int pick;
        units  = (disk_count_q > 4) ? 4 : int'(disk_count_q);
        bpd    = int'(blocks_per_disk_q);
        r.func = ($urandom_range(0, 99) < submit_pct) ? fscan_pkg::FUNC_SUBMIT
                                                      : fscan_pkg::FUNC_DISPATCH;
        r.tag  = fscan_pkg::TAG_W'($urandom);
        r.raw  = 1'($urandom);
        if (units == 0 || $urandom_range(0, 99) < 10)
            r.unit = fscan_pkg::UNIT_W'($urandom);
        else
            r.unit = fscan_pkg::UNIT_W'($urandom_range(0, units - 1));
        pick = $urandom_range(0, 99);
        if (bpd == 0 || pick < 10)
            r.block = fscan_pkg::BLOCK_W'($urandom);
        else if (pick < 40)
            r.block = fscan_pkg::BLOCK_W'($urandom_range(0, ((bpd > 96) ? 96 : bpd) - 1));
        else if (pick < 50)
            r.block = fscan_pkg::BLOCK_W'(bpd - 1 -
                                          $urandom_range(0, (bpd > 8) ? 8 : bpd - 1));
        else
            r.block = fscan_pkg::BLOCK_W'($urandom_range(0, bpd - 1));
        return r;
    endfunction

    // receiver: stall pattern of its own, plus one long hold-off on request
    initial begin
        rsp_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (long_hold_request) begin
                long_hold_request = 1'b0;
                rsp_if.ready <= 1'b0;
                for (hold_count = 0; hold_count < LONG_HOLD_CYCLES; hold_count++)
                    @(negedge i_clk);
            end
            if (mode_left == 0) begin
                stall_mode = t_rsp_mode'($urandom_range(0, 3));
                mode_left  = $urandom_range(16, 80);
            end
            mode_left--;
            pattern_count++;
            case (stall_mode)
                RSP_ALWAYS:   rsp_if.ready <= 1'b1;
                RSP_RANDOM:   rsp_if.ready <= 1'($urandom);
                RSP_SPARSE:   rsp_if.ready <= ($urandom_range(0, 3) == 0);
                default:      rsp_if.ready <= (pattern_count % 5 != 0);
            endcase
        end
    end

    function automatic void check_field(input string name, input logic [15:0] want,
                                        input logic [15:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            error_count++;
        end
    endfunction

    // result checker: each transaction against the oldest expectation
    always @(posedge i_clk) begin : result_check
        t_disk_result want;
        if (i_rst_n && rsp_if.valid && rsp_if.ready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual status %0d",
                         $time, rsp_if.status);
                error_count++;
            end else begin
                want = pending_results.pop_front();
                check_field("status", 16'(want.status), 16'(rsp_if.status));
                check_field("out_tag", 16'(want.tag), 16'(rsp_if.out_tag));
                check_field("cylinder", 16'(want.cyl), 16'(rsp_if.cylinder));
                check_field("sector", 16'(want.sec), 16'(rsp_if.sector));
                check_field("direction", 16'(want.dir), 16'(rsp_if.direction));
            end
        end
    end

    // defaults after reset: checks, sector split, cylinder order, sweep swap
    task automatic test_reset_defaults();
        send_fields(fscan_pkg::FUNC_DISPATCH, 0, 0, 0, 1'b0);      // nothing pending
        send_fields(fscan_pkg::FUNC_SUBMIT, 1, 2, 100, 1'b0);      // bad unit
        send_fields(fscan_pkg::FUNC_SUBMIT, 2, 3, 65535, 1'b1);    // unit check before bound
        send_fields(fscan_pkg::FUNC_SUBMIT, 3, 0, 9792, 1'b1);     // past end, raw read
        send_fields(fscan_pkg::FUNC_SUBMIT, 4, 1, 65535, 1'b0);    // past end, error
        send_fields(fscan_pkg::FUNC_SUBMIT, 255, 1, 9791, 1'b1);   // last valid block
        send_fields(fscan_pkg::FUNC_SUBMIT, 0, 0, 0, 1'b0);
        send_fields(fscan_pkg::FUNC_SUBMIT, 7, 0, 12, 1'b0);       // sector past the split
        send_fields(fscan_pkg::FUNC_SUBMIT, 8, 1, 23, 1'b1);       // highest sector
        send_fields(fscan_pkg::FUNC_SUBMIT, 9, 0, 100, 1'b0);
        repeat (6) send_fields(fscan_pkg::FUNC_DISPATCH, 0, 0, 0, 1'b0);
        send_fields(fscan_pkg::FUNC_SUBMIT, 10, 1, 2000, 1'b0);
        send_fields(fscan_pkg::FUNC_SUBMIT, 11, 0, 50, 1'b0);      // ascending pass now
        repeat (2) send_fields(fscan_pkg::FUNC_DISPATCH, 0, 0, 0, 1'b0);
    endtask

    // register extremes, including zero counts and a wide data word
    task automatic test_config_extremes();
        wait_for_idle();
        write_register(fscan_pkg::CFG_DISK_COUNT, 16'd0);
        send_fields(fscan_pkg::FUNC_SUBMIT, 20, 0, 5, 1'b0);       // every unit rejected
        wait_for_idle();
        write_register(fscan_pkg::CFG_DISK_COUNT, 16'hFFFF);       // seven units after masking
        write_register(fscan_pkg::CFG_BLOCKS_PER_DISK, 16'd0);
        send_fields(fscan_pkg::FUNC_SUBMIT, 21, 3, 0, 1'b0);       // every block past end
        wait_for_idle();
        write_register(fscan_pkg::CFG_BLOCKS_PER_DISK, 16'hFFFF);
        send_fields(fscan_pkg::FUNC_SUBMIT, 22, 3, 65535, 1'b1);
        send_fields(fscan_pkg::FUNC_SUBMIT, 23, 2, 65534, 1'b0);
        send_fields(fscan_pkg::FUNC_DISPATCH, 0, 0, 0, 1'b0);
        wait_for_idle();
        write_register(fscan_pkg::CFG_BLOCKS_PER_DISK, fscan_pkg::BLOCKS_PER_DISK_RST);
        write_register(fscan_pkg::CFG_DISK_COUNT, 16'd4);
    endtask

    // long receiver hold-off while submits pile into a full queue
    task automatic test_backpressure();
        int n;
        wait_for_idle();
        long_hold_request = 1'b1;
        for (n = 0; n < 20; n++)
            send_fields(fscan_pkg::FUNC_SUBMIT, $urandom, $urandom_range(0, 3),
                        $urandom_range(0, 9791), 1'($urandom));
        for (n = 0; n < 20; n++)
            send_fields(fscan_pkg::FUNC_DISPATCH, $urandom, $urandom, $urandom,
                        1'($urandom));
    endtask

    // random traffic over several register settings
    task automatic test_random_traffic();
        int phase;
        int n;
        int submit_pct;
        int count;
        for (phase = 0; phase < RANDOM_PHASES; phase++) begin
            wait_for_idle();
            case (phase)
                0: begin
                    write_register(fscan_pkg::CFG_BLOCKS_PER_DISK, 16'd1);
                    write_register(fscan_pkg::CFG_DISK_COUNT, 16'd1);
                end
                RANDOM_PHASES - 1: begin
                    write_register(fscan_pkg::CFG_BLOCKS_PER_DISK, 16'hFFFF);
                    write_register(fscan_pkg::CFG_DISK_COUNT, 16'd4);
                end
                default: begin
                    case ($urandom_range(0, 3))
                        0: write_register(fscan_pkg::CFG_BLOCKS_PER_DISK,
                                          16'($urandom_range(1, 200)));
                        1: write_register(fscan_pkg::CFG_BLOCKS_PER_DISK,
                                          fscan_pkg::BLOCKS_PER_DISK_RST);
                        2: write_register(fscan_pkg::CFG_BLOCKS_PER_DISK,
                                          16'($urandom_range(1, 65535)));
                        default: write_register(fscan_pkg::CFG_BLOCKS_PER_DISK,
                                                16'($urandom_range(30000, 65535)));
                    endcase
                    count = ($urandom_range(0, 9) < 2) ? $urandom_range(0, 7)
                                                       : $urandom_range(1, 4);
                    write_register(fscan_pkg::CFG_DISK_COUNT, {13'($urandom), 3'(count)});
                end
            endcase
            submit_pct = $urandom_range(35, 85);
            for (n = 0; n < ITEMS_PER_PHASE; n++)
                send_request(random_request(submit_pct));
        end
    endtask

    // drain, settle and report
    task automatic finish_run();
        wait_for_idle();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (error_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    endtask

    // test sequence
    initial begin
        i_rst_n             = 1'b0;
        req_if.valid        = 1'b0;
        req_if.func         = fscan_pkg::FUNC_SUBMIT;
        req_if.request_tag  = '0;
        req_if.disk_unit    = '0;
        req_if.block_number = '0;
        req_if.raw_read     = 1'b0;
        cfg_if.valid        = 1'b0;
        cfg_if.index        = fscan_pkg::CFG_BLOCKS_PER_DISK;
        cfg_if.data         = '0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_reset_defaults();
        test_config_extremes();
        test_backpressure();
        test_random_traffic();
        finish_run();
    end

endmodule

>>> files.f
+incdir+src
src/fscan_pkg.sv
src/fscan_req_if.sv
src/fscan_rsp_if.sv
src/fscan_cfg_if.sv
src/fscan_ctrl.sv
src/fscan_dp.sv
src/fscan_disk_request_scheduler_top.sv
sim/fscan_disk_request_scheduler_top_tb.sv
